### rtl/ldq_pkg.sv
// ldq_pkg: shared types and constants of the link delay tail drop queue
// request and result payload structs, command, event and register codes
// no dependencies
package ldq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TIME_BITS_DEF   = 32;
  localparam int QB_BITS         = 24;
  localparam int TPB_FRAC_BITS   = 16;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 32;

  typedef enum logic {
    CMD_ARRIVAL = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_e;

  typedef enum logic {
    EV_FORWARD = 1'b0,
    EV_DROP    = 1'b1
  } event_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAX_QUEUE_BYTES = 2'd0,
    REG_LATENCY_TICKS   = 2'd1,
    REG_TICKS_PER_BYTE  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] pkt_tag;
    logic [15:0] pkt_bytes;
    logic        droppable;
  } req_t;

  typedef struct packed {
    event_e      event_kind;
    logic [15:0] out_tag;
    logic [15:0] out_bytes;
  } rsp_t;

endpackage

### rtl/ldq_ram.sv
// ldq_ram: generic single write port, single read port ram
// read data is registered, old data on read during write
// no dependencies
module ldq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ldq_out_buf.sv
// ldq_out_buf: two entry result buffer between the queue logic and the receiver
// depends on ldq_pkg for the result struct
module ldq_out_buf
  import ldq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rsp_t push_data,
  output logic full,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic [1:0] ocnt;
  logic [1:0] ocnt_next;
  rsp_t       s0;
  rsp_t       s1;
  logic       pop;

  assign pop       = rsp_valid && rsp_ready;
  assign rsp_valid = (ocnt != 2'd0);
  assign full      = (ocnt == 2'd2);
  assign rsp       = s0;
  assign ocnt_next = ocnt + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      ocnt <= ocnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && ocnt == 2'd1) begin
        s0 <= push_data;
      end else begin
        s0 <= s1;
      end
      if (push && ocnt == 2'd2) begin
        s1 <= push_data;
      end
    end else if (push) begin
      if (ocnt == 2'd0) begin
        s0 <= push_data;
      end else begin
        s1 <= push_data;
      end
    end
  end

endmodule

### rtl/link_delay_tail_drop_queue.sv
// link_delay_tail_drop_queue: link emulator queue with tail drop, fixed delay
// and serialization rate shaping; depends on ldq_pkg, ldq_ram, ldq_out_buf
//
// usage:
//   req channel (req_valid/req_ready/req): each request is a packet arrival or
//   one time tick. rsp channel (rsp_valid/rsp_ready/rsp): forwarded or dropped
//   packet reports, at most one per request.
//   cfg port (cfg_we/cfg_idx/cfg_data): write max_queue_bytes, latency_ticks,
//   ticks_per_byte_q16 while no request is in flight.
// timing:
//   one request per cycle while req_ready is high. results are registered in the
//   output buffer before they appear on rsp. packets sit in a ring in one ram;
//   the head entry is held in registers and the entry behind it is read from
//   the ram ahead of use, with a bypass when it was written the cycle before.
// reset:
//   clears time, queue count, byte count, pointers and config registers. the
//   ram needs no clearing pass: only written entries are ever read.
// stall:
//   results collect in a two entry buffer; req_ready drops while both are
//   held and rises again once the receiver takes one.
module link_delay_tail_drop_queue
  import ldq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  req_t                     req,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output rsp_t                     rsp,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TIME_BITS + 32;
  localparam int PRODW = 16 + CFG_DATA_BITS;

  function automatic logic reached(input logic [TIME_BITS-1:0] now,
                                   input logic [TIME_BITS-1:0] t);
    logic [TIME_BITS-1:0] d;
    d = now - t;
    return !d[TIME_BITS-1];
  endfunction

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // config
  logic [QB_BITS-1:0]       max_qb;
  logic [CFG_DATA_BITS-1:0] lat;
  logic [CFG_DATA_BITS-1:0] tpb;
  logic [CFG_DATA_BITS-1:0] tpb_next;

  // queue state
  logic [TIME_BITS-1:0] tick_now;
  logic [CW-1:0]        count;
  logic [QB_BITS-1:0]   queued_bytes;
  logic                 ser;
  logic [TIME_BITS-1:0] ser_start;
  logic [PW-1:0]        head_pos1;
  logic [PW-1:0]        tail_pos;
  logic [TIME_BITS-1:0] h0_ready;
  logic [15:0]          h0_bytes;
  logic [15:0]          h0_tag;
  logic [TIME_BITS-1:0] h0_delay;
  logic                 fwd;
  logic [EW-1:0]        fwd_data;

  // ram
  logic [PW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic [EW-1:0] wr_data;

  // datapath
  logic                 req_fire;
  logic                 tick_fire;
  logic                 arr_fire;
  logic [TIME_BITS-1:0] tick_nx;
  logic [EW-1:0]        h1;
  logic [TIME_BITS-1:0] h1_ready;
  logic [15:0]          h1_bytes;
  logic [15:0]          h1_tag;
  logic                 start0;
  logic                 ser_eff;
  logic [TIME_BITS-1:0] start_eff;
  logic [TIME_BITS-1:0] fin_diff;
  logic                 dep;
  logic                 more;
  logic                 restart;
  logic                 ser_next;
  logic [QB_BITS:0]     qb_sum;
  logic                 over;
  logic                 q_full;
  logic                 drop;
  logic                 enq;
  logic                 load_arr;
  logic                 load_dep;
  logic [15:0]          mul_bytes;
  logic [PRODW-1:0]     prod;
  logic [CFG_DATA_BITS-1:0] delay_full;
  logic                 push;
  rsp_t                 push_data;
  logic                 obuf_full;

  assign req_ready = !obuf_full;
  assign req_fire  = req_valid && req_ready;
  assign tick_fire = req_fire && (req.cmd == CMD_TICK);
  assign arr_fire  = req_fire && (req.cmd == CMD_ARRIVAL);
  assign tick_nx   = tick_now + TIME_BITS'(1);

  assign h1       = fwd ? fwd_data : rd_data;
  assign h1_ready = h1[EW-1 -: TIME_BITS];
  assign h1_bytes = h1[31:16];
  assign h1_tag   = h1[15:0];

  // departure side
  assign start0    = tick_fire && !ser && (count != '0) && reached(tick_nx, h0_ready);
  assign ser_eff   = ser || start0;
  assign start_eff = start0 ? tick_nx : ser_start;
  assign fin_diff  = tick_nx - start_eff - h0_delay;
  assign dep       = tick_fire && ser_eff && !fin_diff[TIME_BITS-1];
  assign more      = (count > CW'(1));
  assign restart   = dep && more && reached(tick_nx, h1_ready);
  assign ser_next  = dep ? restart : ser_eff;

  // arrival side
  assign qb_sum = {1'b0, queued_bytes} + (QB_BITS + 1)'(req.pkt_bytes);
  assign over   = req.droppable && (max_qb != '0) && (qb_sum > {1'b0, max_qb});
  assign q_full = (count == CW'(QUEUE_DEPTH));
  assign drop   = arr_fire && (over || q_full);
  assign enq    = arr_fire && !drop;

  assign wr_data = {tick_now + TIME_BITS'(lat), req.pkt_bytes, req.pkt_tag};
  assign rd_addr = dep ? wrap_inc(head_pos1) : head_pos1;

  // serialization delay of the head entry, computed as it is loaded and again while idle
  assign load_arr   = enq && (count == '0);
  assign load_dep   = dep && more;
  assign tpb_next   = (cfg_we && cfg_idx == REG_TICKS_PER_BYTE) ? cfg_data : tpb;
  assign mul_bytes  = load_arr ? req.pkt_bytes : (load_dep ? h1_bytes : h0_bytes);
  assign prod       = PRODW'(mul_bytes) * PRODW'(tpb_next);
  assign delay_full = prod[PRODW-1 -: CFG_DATA_BITS];

  assign push = drop || dep;
  always_comb begin
    if (drop) begin
      push_data = '{event_kind: EV_DROP, out_tag: req.pkt_tag, out_bytes: req.pkt_bytes};
    end else begin
      push_data = '{event_kind: EV_FORWARD, out_tag: h0_tag, out_bytes: h0_bytes};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_qb <= '0;
      lat    <= '0;
      tpb    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MAX_QUEUE_BYTES: max_qb <= cfg_data[QB_BITS-1:0];
        REG_LATENCY_TICKS:   lat    <= cfg_data;
        REG_TICKS_PER_BYTE:  tpb    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now     <= '0;
      count        <= '0;
      queued_bytes <= '0;
      ser          <= 1'b0;
      ser_start    <= '0;
      head_pos1    <= PW'(1);
      tail_pos     <= '0;
      fwd          <= 1'b0;
    end else begin
      fwd <= enq && (tail_pos == rd_addr);
      if (tick_fire) begin
        tick_now <= tick_nx;
      end
      ser <= ser_next;
      if (start0 || restart) begin
        ser_start <= tick_nx;
      end
      if (enq) begin
        count    <= count + CW'(1);
        tail_pos <= wrap_inc(tail_pos);
        queued_bytes <= qb_sum[QB_BITS] ? {QB_BITS{1'b1}} : qb_sum[QB_BITS-1:0];
      end else if (dep) begin
        count     <= count - CW'(1);
        head_pos1 <= wrap_inc(head_pos1);
        queued_bytes <= (queued_bytes > QB_BITS'(h0_bytes)) ?
                        queued_bytes - QB_BITS'(h0_bytes) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wr_data;
    if (load_arr) begin
      h0_ready <= wr_data[EW-1 -: TIME_BITS];
      h0_bytes <= req.pkt_bytes;
      h0_tag   <= req.pkt_tag;
    end else if (load_dep) begin
      h0_ready <= h1_ready;
      h0_bytes <= h1_bytes;
      h0_tag   <= h1_tag;
    end
    if (load_arr || load_dep || !ser_next) begin
      h0_delay <= TIME_BITS'(delay_full);
    end
  end

  ldq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (enq),
    .waddr (tail_pos),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ldq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (obuf_full),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ser_nonempty: assert property (@(posedge clk) disable iff (rst)
    ser |-> (count != '0))
    else $error("serializing with empty queue");

  a_dep_count: assert property (@(posedge clk) disable iff (rst)
    dep |=> (count == $past(count) - CW'(1)))
    else $error("departure did not release an entry");

  a_drop_hold: assert property (@(posedge clk) disable iff (rst)
    drop |=> ($stable(count) && $stable(tail_pos)))
    else $error("dropped packet changed the queue");

endmodule
